FILE: rtl/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg: shared types and codes for the consistent hash ring
// Operation and status codes plus the front-to-back command record.
// ----------------------------------------------------------------------------
package chr_pkg;

	typedef enum logic [1:0] {
		OP_ROUTE  = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	localparam int HASH_W = 64;
	localparam int IN_NODE_W = 8;
	localparam int OUT_NODE_W = 8;
	localparam int COUNT_W = 7;

	typedef struct packed {
		op_t                  op;
		logic [HASH_W-1:0]    key;
		logic [IN_NODE_W-1:0] node;
	} cmd_t;

endpackage

FILE: rtl/chr_front.sv
// ----------------------------------------------------------------------------
// chr_front: input stage and command queue
// Accepts items, converts the hash to an unsigned order key, queues them.
// ----------------------------------------------------------------------------
module chr_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  chr_pkg::cmd_t     in_cmd,
	output logic              q_valid,
	input  logic              q_pop,
	output chr_pkg::cmd_t     q_cmd
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	chr_pkg::cmd_t     mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              push;
	chr_pkg::cmd_t     cls;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_cmd = mem_q[rd_q];

	// flip the sign bit so unsigned compare gives signed order
	always_comb begin
		cls = in_cmd;
		cls.key[chr_pkg::HASH_W-1] = ~in_cmd.key[chr_pkg::HASH_W-1];
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

FILE: rtl/chr_back.sv
// ----------------------------------------------------------------------------
// chr_back: ring store and slot scanner
// Walks all slots one per cycle to route, insert or remove, then emits; clear skips the walk.
// ----------------------------------------------------------------------------
module chr_back #(
	parameter int RING_SLOTS = 64,
	parameter int NODE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  chr_pkg::cmd_t                 q_cmd,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [chr_pkg::OUT_NODE_W-1:0] routed_node,
	output logic [chr_pkg::COUNT_W-1:0]   entry_count
);
	localparam int SW = $clog2(RING_SLOTS);
	localparam int CW = $clog2(RING_SLOTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_DONE} state_t;

	logic [chr_pkg::HASH_W-1:0] pos_mem [RING_SLOTS];
	logic [NODE_BITS-1:0]       node_mem [RING_SLOTS];
	logic [RING_SLOTS-1:0]      valid_q;
	logic [CW-1:0]              used_q;

	state_t                     state_q;
	chr_pkg::cmd_t              cmd_q;
	logic [NODE_BITS-1:0]       cmd_node_q;
	logic [SW:0]                idx_q;
	logic [chr_pkg::HASH_W-1:0] rd_pos_q;
	logic [NODE_BITS-1:0]       rd_node_q;
	logic                       rd_ok_q;
	logic [SW-1:0]              rd_idx_q;
	logic                       have_up_q, have_low_q, have_free_q, hit_q;
	logic [chr_pkg::HASH_W-1:0] best_up_q, best_low_q;
	logic [NODE_BITS-1:0]       node_up_q, node_low_q;
	logic [SW-1:0]              free_q, hit_idx_q;
	logic [NODE_BITS-1:0]       cmd_node;
	logic                       out_fire;

	assign cmd_node = NODE_BITS'(q_cmd.node);
	assign out_fire = out_valid && !out_stall;
	assign q_pop = (state_q == S_IDLE) && q_valid && !out_valid;

	// memory read, one slot per cycle, registered
	always_ff @(posedge clk) begin
		rd_pos_q <= pos_mem[idx_q[SW-1:0]];
		rd_node_q <= node_mem[idx_q[SW-1:0]];
		rd_idx_q <= idx_q[SW-1:0];
		if (state_q == S_DONE && cmd_q.op == chr_pkg::OP_INSERT) begin
			if (hit_q) begin
				node_mem[hit_idx_q] <= cmd_node_q;
			end else if (have_free_q) begin
				pos_mem[free_q] <= cmd_q.key;
				node_mem[free_q] <= cmd_node_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			used_q <= '0;
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			out_valid <= 1'b0;
			status <= '0;
			routed_node <= '0;
			entry_count <= '0;
			have_up_q <= 1'b0;
			have_low_q <= 1'b0;
			have_free_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (out_fire) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rd_ok_q <= 1'b0;
					if (q_pop) begin
						cmd_q <= q_cmd;
						cmd_node_q <= cmd_node;
						idx_q <= '0;
						have_up_q <= 1'b0;
						have_low_q <= 1'b0;
						have_free_q <= 1'b0;
						hit_q <= 1'b0;
						state_q <= (q_cmd.op == chr_pkg::OP_CLEAR) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN, S_LAST: begin
					rd_ok_q <= (state_q == S_SCAN);
					if (state_q == S_SCAN) begin
						if (idx_q == (SW+1)'(RING_SLOTS-1)) state_q <= S_LAST;
						else idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
					if (rd_ok_q) begin
						if (valid_q[rd_idx_q]) begin
							if (!have_low_q || rd_pos_q < best_low_q) begin
								have_low_q <= 1'b1;
								best_low_q <= rd_pos_q;
								node_low_q <= rd_node_q;
							end
							if (rd_pos_q >= cmd_q.key &&
							    (!have_up_q || rd_pos_q < best_up_q)) begin
								have_up_q <= 1'b1;
								best_up_q <= rd_pos_q;
								node_up_q <= rd_node_q;
							end
							if (!hit_q && rd_pos_q == cmd_q.key) begin
								hit_q <= 1'b1;
								hit_idx_q <= rd_idx_q;
							end
						end else if (!have_free_q) begin
							have_free_q <= 1'b1;
							free_q <= rd_idx_q;
						end
					end
				end
				S_DONE: begin
					routed_node <= '0;
					status <= chr_pkg::ST_OK;
					entry_count <= chr_pkg::COUNT_W'(used_q);
					case (cmd_q.op)
						chr_pkg::OP_ROUTE: begin
							if (used_q == '0) status <= chr_pkg::ST_EMPTY;
							else routed_node <= chr_pkg::OUT_NODE_W'(
								have_up_q ? node_up_q : node_low_q);
						end
						chr_pkg::OP_INSERT: begin
							if (!hit_q) begin
								if (have_free_q) begin
									valid_q[free_q] <= 1'b1;
									used_q <= used_q + 1'b1;
									entry_count <= chr_pkg::COUNT_W'(used_q + 1'b1);
								end else begin
									status <= chr_pkg::ST_FULL;
								end
							end
						end
						chr_pkg::OP_CLEAR: begin
							valid_q <= '0;
							used_q <= '0;
							entry_count <= '0;
						end
						default: ;
					endcase
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// remove clears matching slots as the scan passes them
			if ((state_q == S_SCAN || state_q == S_LAST) && rd_ok_q &&
			    cmd_q.op == chr_pkg::OP_REMOVE && valid_q[rd_idx_q] &&
			    rd_node_q == cmd_node_q) begin
				valid_q[rd_idx_q] <= 1'b0;
				used_q <= used_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/consistent_hash_ring.sv
// Route, insert and remove each scan every ring slot before the result; clear
// skips the scan. The single slot scanner reads one ring entry per cycle from
// the slot memory and starts a new item only after the last result is taken.
// Reset: arst_n empties the ring and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
// consistent_hash_ring: consistent hashing ring with virtual nodes
// Front queue converts each hash to an order key; back scanner keeps the ring and answers.
// ----------------------------------------------------------------------------
module consistent_hash_ring #(
	parameter int RING_SLOTS = 64,
	parameter int NODE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic signed [63:0] hash,
	input  logic [7:0]  node_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  routed_node,
	output logic [6:0]  entry_count
);
	chr_pkg::cmd_t in_cmd, q_cmd;
	logic          q_valid, q_pop;

	// pack the transfer into one command record
	always_comb begin
		in_cmd.op = chr_pkg::op_t'(operation);
		in_cmd.key = hash;
		in_cmd.node = node_id;
	end

	// front: hold up to two commands while the scanner is busy
	chr_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	// back: scan the ring and drive the result register
	chr_back #(.RING_SLOTS(RING_SLOTS), .NODE_BITS(NODE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .routed_node(routed_node), .entry_count(entry_count)
	);
endmodule

FILE: rtl/chr_checker.sv
// ----------------------------------------------------------------------------
// chr_assert: port-level checks for the hash ring
// Watches results and handshakes on the top-level ports.
// ----------------------------------------------------------------------------
module chr_assert (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] routed_node,
	input logic [6:0] entry_count
);
	// a result never reports the reserved status code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != chr_pkg::ST_RSVD) else $error("bad status");
	// only a good route names a node
	a_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != chr_pkg::ST_OK |-> routed_node == '0)
		else $error("node on failure");
	// an empty ring reports no entries
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == chr_pkg::ST_EMPTY |-> entry_count == '0)
		else $error("empty with entries");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_count))
		else $error("result dropped");
endmodule

bind consistent_hash_ring chr_assert u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .routed_node(routed_node), .entry_count(entry_count)
);

FILE: tb/sv/chr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chr_checker: result predictor and comparator for the consistent hash ring
// Mirrors the ring from accepted requests and checks each accepted answer.
// ----------------------------------------------------------------------------
module chr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [63:0] hash,
	input  logic [7:0]         node_id,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic [7:0]         routed_node,
	input  logic [6:0]         entry_count,
	output int                 fail_count,
	output int                 pending_answers,
	output int                 answer_count
);

	localparam int SLOTS = 64;

	typedef struct packed {
		chr_pkg::status_t st;
		logic [7:0]       node;
		logic [6:0]       count;
	} answer_t;

	logic signed [63:0] ring_pos [SLOTS];
	logic [7:0]         ring_node [SLOTS];
	logic               ring_used [SLOTS];
	int                 ring_size;
	answer_t            answer_q [$];

	function automatic answer_t ring_apply(chr_pkg::op_t op, logic signed [63:0] h,
		logic [7:0] nid);
		answer_t a;
		int free_slot;
		logic have_up, have_low, hit;
		logic signed [63:0] best_up, best_low;
		logic [7:0] node_up, node_low;
		a = '{chr_pkg::ST_OK, 8'd0, 7'd0};
		free_slot = -1;
		have_up = 0;
		have_low = 0;
		hit = 0;
		best_up = 0;
		best_low = 0;
		node_up = 0;
		node_low = 0;
		case (op)
			chr_pkg::OP_ROUTE: begin
				if (ring_size == 0) begin
					a.st = chr_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < SLOTS; i++) begin
						if (ring_used[i]) begin
							if (!have_low || ring_pos[i] < best_low) begin
								have_low = 1;
								best_low = ring_pos[i];
								node_low = ring_node[i];
							end
							if (ring_pos[i] >= h && (!have_up || ring_pos[i] < best_up)) begin
								have_up = 1;
								best_up = ring_pos[i];
								node_up = ring_node[i];
							end
						end
					end
					a.node = have_up ? node_up : node_low;
				end
			end
			chr_pkg::OP_INSERT: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (ring_used[i]) begin
						if (!hit && ring_pos[i] == h) begin
							ring_node[i] = nid;
							hit = 1;
						end
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (!hit) begin
					if (free_slot < 0) begin
						a.st = chr_pkg::ST_FULL;
					end else begin
						ring_used[free_slot] = 1;
						ring_pos[free_slot] = h;
						ring_node[free_slot] = nid;
						ring_size++;
					end
				end
			end
			chr_pkg::OP_REMOVE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (ring_used[i] && ring_node[i] == nid) begin
						ring_used[i] = 0;
						ring_size--;
					end
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					ring_used[i] = 0;
				ring_size = 0;
			end
		endcase
		a.count = 7'(ring_size);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				ring_used[i] = 0;
			ring_size = 0;
			answer_q.delete();
			fail_count = 0;
			answer_count = 0;
			pending_answers = 0;
		end else begin
			// retire the answer first: its request is always older than the one in flight
			if (out_valid && !out_stall) begin
				answer_count++;
				if (answer_q.size() == 0) begin
					$error("answer with no request outstanding");
					fail_count++;
				end else begin
					exp_a = answer_q.pop_front();
					if (status !== exp_a.st) begin
						$error("status: expected %0d, actual %0d", exp_a.st, status);
						fail_count++;
					end
					if (routed_node !== exp_a.node) begin
						$error("routed_node: expected %0d, actual %0d", exp_a.node,
							routed_node);
						fail_count++;
					end
					if (entry_count !== exp_a.count) begin
						$error("entry_count: expected %0d, actual %0d", exp_a.count,
							entry_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				answer_q.push_back(ring_apply(chr_pkg::op_t'(operation), hash, node_id));
			pending_answers = answer_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_consistent_hash_ring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring: request stimulus and verdict for the hash ring
// Drives directed and random ring traffic with random gaps on both channels;
// a separate checker predicts every answer and counts mismatches.
// ----------------------------------------------------------------------------
module tb_consistent_hash_ring;

	localparam int TOTAL_ITEMS = 550;
	localparam int SLOTS = 64;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic signed [63:0] hash;
	logic [7:0]         node_id;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [7:0]         routed_node;
	logic [6:0]         entry_count;
	int                 fail_count;
	int                 pending_answers;
	int                 answer_count;
	int                 sent_count;
	logic               hold_answers;
	logic               sender_done;

	// small pool of positions so inserts hit existing entries and routes land exactly
	logic signed [63:0] pos_pool [16];

	consistent_hash_ring u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.hash        (hash),
		.node_id     (node_id),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.routed_node (routed_node),
		.entry_count (entry_count)
	);

	chr_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.hash            (hash),
		.node_id         (node_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.routed_node     (routed_node),
		.entry_count     (entry_count),
		.fail_count      (fail_count),
		.pending_answers (pending_answers),
		.answer_count    (answer_count)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// gap length: mostly zero or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic signed [63:0] pick_hash();
		case ($urandom_range(0, 5))
			0, 1, 2: return pos_pool[$urandom_range(0, 15)];
			3:       return {1'b1, 63'd0} + 64'($urandom_range(0, 3));
			4:       return {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// offer one request and hold it until the block takes the transfer
	task automatic send_request(chr_pkg::op_t op, logic signed [63:0] h, logic [7:0] nid);
		in_valid <= 1'b1;
		operation <= op;
		hash <= h;
		node_id <= nid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic send_with_gap(chr_pkg::op_t op, logic signed [63:0] h, logic [7:0] nid);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		send_request(op, h, nid);
	endtask

	// receiver: random stall pattern, with one long forced hold-off
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_answers || sender_done) begin
				out_stall <= hold_answers;
			end else begin
				gap = pick_gap();
				out_stall <= (gap > 0);
				if (gap > 0) begin
					repeat (gap - 1) @(posedge clk);
					@(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// hold off answers for a long stretch mid-run so the block backs up its input
	initial begin
		hold_answers = 1'b0;
		wait (sent_count >= 120);
		@(posedge clk);
		hold_answers <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_answers <= 1'b0;
	end

	initial begin
		int mode;
		int wait_cycles;
		logic [7:0] nid;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = chr_pkg::OP_ROUTE;
		hash = '0;
		node_id = '0;
		sent_count = 0;
		sender_done = 1'b0;
		for (int i = 0; i < 16; i++)
			pos_pool[i] = {$urandom, $urandom};
		pos_pool[0] = {1'b1, 63'd0};
		pos_pool[1] = {1'b0, {63{1'b1}}};
		pos_pool[2] = '0;
		pos_pool[3] = -64'sd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, extremes, overwrite, wrap, removes, clear
		send_request(chr_pkg::OP_ROUTE, 64'sd5, 8'd0);
		send_request(chr_pkg::OP_REMOVE, '0, 8'd9);
		send_request(chr_pkg::OP_INSERT, {1'b1, 63'd0}, 8'hFF);
		send_request(chr_pkg::OP_INSERT, {1'b0, {63{1'b1}}}, 8'h00);
		send_request(chr_pkg::OP_INSERT, 64'sd0, 8'h5A);
		send_request(chr_pkg::OP_ROUTE, {1'b1, 63'd0}, 8'd0);
		send_request(chr_pkg::OP_ROUTE, 64'sd1, 8'd0);
		send_request(chr_pkg::OP_ROUTE, {1'b0, {63{1'b1}}}, 8'd0);
		send_request(chr_pkg::OP_INSERT, 64'sd0, 8'hA5);
		send_request(chr_pkg::OP_ROUTE, -64'sd1, 8'd0);
		send_request(chr_pkg::OP_REMOVE, '0, 8'h00);
		send_request(chr_pkg::OP_ROUTE, 64'sd7, 8'd0);
		send_request(chr_pkg::OP_REMOVE, '0, 8'h77);
		// fill the ring, overwrite while full, then overflow
		for (int i = 0; i < SLOTS; i++)
			send_request(chr_pkg::OP_INSERT, 64'sd1000 * i - 64'sd9000, 8'(i % 5));
		send_request(chr_pkg::OP_INSERT, 64'sd2000, 8'hC3);
		send_request(chr_pkg::OP_INSERT, 64'sd2001, 8'hC3);
		send_request(chr_pkg::OP_ROUTE, 64'sd2500, 8'd0);
		send_request(chr_pkg::OP_REMOVE, '0, 8'd3);
		send_request(chr_pkg::OP_INSERT, 64'sd2001, 8'h3C);
		send_request(chr_pkg::OP_CLEAR, {$urandom, $urandom}, 8'($urandom));
		send_request(chr_pkg::OP_ROUTE, '0, 8'd0);

		// random: mostly build-and-route traffic over a small node set
		while (sent_count < TOTAL_ITEMS) begin
			mode = $urandom_range(0, 99);
			nid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			if (mode < 40)
				send_with_gap(chr_pkg::OP_INSERT, pick_hash(), nid);
			else if (mode < 80)
				send_with_gap(chr_pkg::OP_ROUTE, pick_hash(), 8'($urandom));
			else if (mode < 95)
				send_with_gap(chr_pkg::OP_REMOVE, {$urandom, $urandom}, nid);
			else if (mode < 97)
				send_with_gap(chr_pkg::OP_CLEAR, {$urandom, $urandom}, 8'($urandom));
			else begin
				// burst of inserts to push the ring to full
				for (int k = 0; k < 70 && sent_count < TOTAL_ITEMS; k++)
					send_request(chr_pkg::OP_INSERT, {$urandom, $urandom}, 8'($urandom));
			end
		end
		in_valid <= 1'b0;
		sender_done <= 1'b1;

		wait_cycles = 0;
		while (pending_answers != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (80) @(posedge clk);
		$display("Ran %0d requests, %0d answers: route, insert incl. full ring and", sent_count,
			answer_count);
		$display("overwrite, remove, clear, signed extremes, random gaps and a long stall.");
		if (fail_count == 0 && pending_answers == 0)
			$display("PASS consistent_hash_ring");
		else
			$display("FAIL consistent_hash_ring");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#20ms;
		$display("FAIL consistent_hash_ring");
		$finish;
	end

endmodule
